>>> rtl/hsvrgb_pkg.sv
// Shared widths, constants, codes and item types of the HSV to RGB brightness pipeline.
package hsvrgb_pkg;

	// Field widths.
	localparam int IDX_W  = 10;
	localparam int CH_W   = 8;
	localparam int HUE_W  = 16;
	localparam int PCT_W  = 7;
	localparam int GAIN_W = 9;
	localparam int HDEG_W = 9;
	localparam int HOFF_W = 6;

	// Opcodes of a pixel write.
	localparam logic OP_RGB = 1'b0;
	localparam logic OP_HSV = 1'b1;

	// Full-scale levels.
	localparam logic [GAIN_W-1:0] GAIN_FULL  = 9'd256;
	localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
	localparam int                LEVEL_FULL = 255;
	localparam int                HUE_CIRCLE = 360;
	localparam int                SECTOR_DEG = 60;

	// Reciprocals for division by constants: floor(x / d) = (x * RECIP) >> SHIFT.
	// The hue reciprocal rounds down and may leave the quotient one short,
	// which a single compare and subtract puts right.
	localparam logic [15:0] HUE_RECIP = 16'd46603;
	localparam int          HUE_SHIFT = 24;
	localparam logic [12:0] PCT_RECIP = 13'd5243;
	localparam int          PCT_SHIFT = 19;
	localparam logic [14:0] SEC_RECIP = 15'd17477;
	localparam int          SEC_SHIFT = 20;

	// Hue sectors of sixty degrees, named by the two colours they lie between.
	localparam logic [2:0] SEC_RED_YEL = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN = 3'd1;
	localparam logic [2:0] SEC_GRN_CYN = 3'd2;
	localparam logic [2:0] SEC_CYN_BLU = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG = 3'd4;
	localparam logic [2:0] SEC_MAG_RED = 3'd5;

	// One pixel write as it enters the pipeline.
	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  pixel_index;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [HUE_W-1:0]  hue;
		logic [PCT_W-1:0]  saturation;
		logic [PCT_W-1:0]  value_level;
	} pix_item_t;

	// A pixel write after hue reduction and the maximum level.
	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  pixel_index;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [HDEG_W-1:0] hue_deg;
		logic [PCT_W-1:0]  sat;
		logic [CH_W-1:0]   level_hi;
	} hue_item_t;

	// An unscaled RGB pixel.
	typedef struct packed {
		logic [IDX_W-1:0]  pixel_index;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
	} rgb_item_t;

endpackage

>>> rtl/hsvrgb_in_if.sv
// Channel carrying pixel writes into the block.
interface hsvrgb_in_if;
	import hsvrgb_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [IDX_W-1:0]  pixel_index;
	logic [CH_W-1:0]   red_in;
	logic [CH_W-1:0]   green_in;
	logic [CH_W-1:0]   blue_in;
	logic [HUE_W-1:0]  hue;
	logic [PCT_W-1:0]  saturation;
	logic [PCT_W-1:0]  value_level;

	modport source (
		output valid, opcode, pixel_index, red_in, green_in, blue_in,
		       hue, saturation, value_level,
		input  ready
	);

	modport sink (
		input  valid, opcode, pixel_index, red_in, green_in, blue_in,
		       hue, saturation, value_level,
		output ready
	);
endinterface

>>> rtl/hsvrgb_out_if.sv
// Channel carrying scaled pixel colours out of the block.
interface hsvrgb_out_if;
	import hsvrgb_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  pixel_addr;
	logic [CH_W-1:0]   red_out;
	logic [CH_W-1:0]   green_out;
	logic [CH_W-1:0]   blue_out;

	modport source (
		output valid, pixel_addr, red_out, green_out, blue_out,
		input  ready
	);

	modport sink (
		input  valid, pixel_addr, red_out, green_out, blue_out,
		output ready
	);
endinterface

>>> rtl/hsvrgb_hue_reduce.sv
// Two pipeline stages: hue modulo 360, percent clamping and the maximum channel level.
module hsvrgb_hue_reduce (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hsvrgb_pkg::pix_item_t  in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output hsvrgb_pkg::hue_item_t  out_item
);
	import hsvrgb_pkg::*;

	logic                v_s1, v_s2;
	logic                en_s1, en_s2;
	pix_item_t           item_s1;
	logic [7:0]          hq_s1;
	logic [PCT_W-1:0]    sat_s1;
	logic [14:0]         vprod_s1;
	hue_item_t           item_s2;

	logic [31:0]         hue_prod;
	logic [PCT_W-1:0]    sat_cl, val_cl;
	logic [16:0]         h_raw;
	logic [27:0]         hi_prod;
	logic [HDEG_W-1:0]   h_deg;

	// A stage takes a new item when it is empty or its item moves on.
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: estimate of hue / 360 and the clamped percentages.
	always_comb begin
		hue_prod = 32'(in_item.hue) * 32'(HUE_RECIP);
		sat_cl   = (in_item.saturation > PCT_FULL) ? PCT_FULL : in_item.saturation;
		val_cl   = (in_item.value_level > PCT_FULL) ? PCT_FULL : in_item.value_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1  <= in_item;
			hq_s1    <= hue_prod[HUE_SHIFT +: 8];
			sat_s1   <= sat_cl;
			vprod_s1 <= 15'(val_cl) * 15'(LEVEL_FULL);
		end
	end

	// Stage 2: remainder with one correction step, and floor(v * 255 / 100).
	always_comb begin
		h_raw   = {1'b0, item_s1.hue} - 17'(hq_s1) * 17'(HUE_CIRCLE);
		if (h_raw >= 17'(HUE_CIRCLE)) begin
			h_deg = HDEG_W'(h_raw - 17'(HUE_CIRCLE));
		end else begin
			h_deg = HDEG_W'(h_raw);
		end
		hi_prod = 28'(vprod_s1) * 28'(PCT_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2.opcode      <= item_s1.opcode;
			item_s2.pixel_index <= item_s1.pixel_index;
			item_s2.red         <= item_s1.red;
			item_s2.green       <= item_s1.green;
			item_s2.blue        <= item_s1.blue;
			item_s2.hue_deg     <= h_deg;
			item_s2.sat         <= sat_s1;
			item_s2.level_hi    <= hi_prod[PCT_SHIFT +: CH_W];
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

	// The reduced hue is the exact remainder of the hue that entered the stage before.
	a_hue_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2) |=> (32'(item_s2.hue_deg) == 32'($past(item_s1.hue)) % HUE_CIRCLE))
		else $error("hue remainder does not match hue modulo 360");

endmodule

>>> rtl/hsvrgb_convert.sv
// Five pipeline stages: sector split, minimum level, ramp and channel selection.
module hsvrgb_convert (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hsvrgb_pkg::hue_item_t  in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output hsvrgb_pkg::rgb_item_t  out_item
);
	import hsvrgb_pkg::*;

	// Fields that ride along unchanged down to the channel selection.
	typedef struct packed {
		logic             opcode;
		logic [IDX_W-1:0] pixel_index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [2:0]       sector;
	} side_t;

	logic              v_s3, v_s4, v_s5, v_s6, v_s7;
	logic              en_s3, en_s4, en_s5, en_s6, en_s7;
	side_t             side_s3, side_s4, side_s5, side_s6;
	logic [CH_W-1:0]   hi_s3, hi_s4, hi_s5, hi_s6;
	logic [HOFF_W-1:0] off_s3, off_s4;
	logic [14:0]       loprod_s3;
	logic [CH_W-1:0]   lo_s4, lo_s5, lo_s6;
	logic [13:0]       dprod_s5;
	logic [CH_W-1:0]   adj_s6;
	rgb_item_t         item_s7;

	side_t             side_in;
	logic [2:0]        sector;
	logic [HDEG_W-1:0] sec_base;
	logic [27:0]       lo_prod;
	logic [28:0]       adj_prod;
	logic [CH_W-1:0]   up, down;
	rgb_item_t         rgb_sel;

	// A stage takes a new item when it is empty or its item moves on.
	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	// Valid bits of the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 3: sector and offset within it by comparison, and hi * (100 - s).
	always_comb begin
		priority if (in_item.hue_deg >= HDEG_W'(5 * SECTOR_DEG)) begin
			sector   = SEC_MAG_RED;
			sec_base = HDEG_W'(5 * SECTOR_DEG);
		end else if (in_item.hue_deg >= HDEG_W'(4 * SECTOR_DEG)) begin
			sector   = SEC_BLU_MAG;
			sec_base = HDEG_W'(4 * SECTOR_DEG);
		end else if (in_item.hue_deg >= HDEG_W'(3 * SECTOR_DEG)) begin
			sector   = SEC_CYN_BLU;
			sec_base = HDEG_W'(3 * SECTOR_DEG);
		end else if (in_item.hue_deg >= HDEG_W'(2 * SECTOR_DEG)) begin
			sector   = SEC_GRN_CYN;
			sec_base = HDEG_W'(2 * SECTOR_DEG);
		end else if (in_item.hue_deg >= HDEG_W'(SECTOR_DEG)) begin
			sector   = SEC_YEL_GRN;
			sec_base = HDEG_W'(SECTOR_DEG);
		end else begin
			sector   = SEC_RED_YEL;
			sec_base = '0;
		end
		side_in.opcode      = in_item.opcode;
		side_in.pixel_index = in_item.pixel_index;
		side_in.red         = in_item.red;
		side_in.green       = in_item.green;
		side_in.blue        = in_item.blue;
		side_in.sector      = sector;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3   <= side_in;
			hi_s3     <= in_item.level_hi;
			off_s3    <= HOFF_W'(in_item.hue_deg - sec_base);
			loprod_s3 <= 15'(in_item.level_hi) * 15'(PCT_FULL - in_item.sat);
		end
	end

	// Stage 4: the minimum level, floor(hi * (100 - s) / 100).
	assign lo_prod = 28'(loprod_s3) * 28'(PCT_RECIP);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			side_s4 <= side_s3;
			hi_s4   <= hi_s3;
			off_s4  <= off_s3;
			lo_s4   <= lo_prod[PCT_SHIFT +: CH_W];
		end
	end

	// Stage 5: span between the levels times the offset in the sector.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			side_s5  <= side_s4;
			hi_s5    <= hi_s4;
			lo_s5    <= lo_s4;
			dprod_s5 <= 14'(hi_s4 - lo_s4) * 14'(off_s4);
		end
	end

	// Stage 6: the ramp, floor(span * offset / 60).
	assign adj_prod = 29'(dprod_s5) * 29'(SEC_RECIP);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			side_s6 <= side_s5;
			hi_s6   <= hi_s5;
			lo_s6   <= lo_s5;
			adj_s6  <= adj_prod[SEC_SHIFT +: CH_W];
		end
	end

	// Stage 7: place the levels by sector, or pass a direct colour through.
	always_comb begin
		up   = lo_s6 + adj_s6;
		down = hi_s6 - adj_s6;
		rgb_sel.pixel_index = side_s6.pixel_index;
		unique case (side_s6.sector)
			SEC_RED_YEL: begin
				rgb_sel.red = hi_s6; rgb_sel.green = up;    rgb_sel.blue = lo_s6;
			end
			SEC_YEL_GRN: begin
				rgb_sel.red = down;  rgb_sel.green = hi_s6; rgb_sel.blue = lo_s6;
			end
			SEC_GRN_CYN: begin
				rgb_sel.red = lo_s6; rgb_sel.green = hi_s6; rgb_sel.blue = up;
			end
			SEC_CYN_BLU: begin
				rgb_sel.red = lo_s6; rgb_sel.green = down;  rgb_sel.blue = hi_s6;
			end
			SEC_BLU_MAG: begin
				rgb_sel.red = up;    rgb_sel.green = lo_s6; rgb_sel.blue = hi_s6;
			end
			default: begin
				rgb_sel.red = hi_s6; rgb_sel.green = lo_s6; rgb_sel.blue = down;
			end
		endcase
		if (side_s6.opcode == OP_RGB) begin
			rgb_sel.red   = side_s6.red;
			rgb_sel.green = side_s6.green;
			rgb_sel.blue  = side_s6.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			item_s7 <= rgb_sel;
		end
	end

	assign out_valid = v_s7;
	assign out_item  = item_s7;

	// The minimum level never exceeds the maximum.
	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (lo_s4 <= hi_s4))
		else $error("minimum level above maximum level");

	// The ramp stays inside the span, so neither up nor down wraps.
	a_adj_span: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en_s6) |=> (adj_s6 <= hi_s6 - lo_s6))
		else $error("ramp exceeds the span between levels");

endmodule

>>> rtl/hsvrgb_scale.sv
// Brightness register and the output stage that scales each channel by it.
module hsvrgb_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               gain_we,
	input  logic [hsvrgb_pkg::GAIN_W-1:0]      gain_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  hsvrgb_pkg::rgb_item_t              in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output hsvrgb_pkg::rgb_item_t              out_item
);
	import hsvrgb_pkg::*;

	logic [GAIN_W-1:0] gain_q;
	logic              v_s8, en_s8;
	rgb_item_t         item_s8;
	logic [16:0]       r_prod, g_prod, b_prod;

	// Gain register; values above full scale are held as full scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_FULL;
		end else if (gain_we) begin
			gain_q <= (gain_wdata > GAIN_FULL) ? GAIN_FULL : gain_wdata;
		end
	end

	// The output register doubles as the scaling stage.
	assign en_s8    = !v_s8 || out_ready;
	assign in_ready = en_s8;

	always_comb begin
		r_prod = 17'(in_item.red)   * 17'(gain_q);
		g_prod = 17'(in_item.green) * 17'(gain_q);
		b_prod = 17'(in_item.blue)  * 17'(gain_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			item_s8.pixel_index <= in_item.pixel_index;
			item_s8.red         <= r_prod[CH_W +: CH_W];
			item_s8.green       <= g_prod[CH_W +: CH_W];
			item_s8.blue        <= b_prod[CH_W +: CH_W];
		end
	end

	assign out_valid = v_s8;
	assign out_item  = item_s8;

	// A write above full scale leaves the register at full scale.
	a_gain_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_we && gain_wdata > GAIN_FULL) |=> (gain_q == GAIN_FULL))
		else $error("brightness gain not clamped at full scale");

endmodule

>>> rtl/hsv_to_rgb_brightness.sv
// Top level of the pixel colour pipeline: HSV or direct RGB writes, scaled by brightness.
// Each pixel write on pixel_item yields one colour on color_item. A new item is taken every
// clock while the output is not stalled; the rate is set by the
// eight-stage pipeline, in which each division by 360, 100 or 60 is a registered
// multiplication by a reciprocal (hue remainder, maximum level, minimum level, ramp) and the
// last stage multiplies each channel by the brightness gain. A write of opcode 0 passes its
// RGB levels through; opcode 1 converts hue (degrees, taken modulo 360), saturation and value
// (percent, clamped at 100). The gain is written through gain_we and gain_wdata in units of
// 1/256, reset to 256, and any value above 256 acts as 256; write it only while the pipeline
// is empty. The pixel index is carried through unchanged.
module hsv_to_rgb_brightness (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           gain_we,
	input  logic [hsvrgb_pkg::GAIN_W-1:0]  gain_wdata,
	hsvrgb_in_if.sink                      pixel_item,
	hsvrgb_out_if.source                   color_item
);
	import hsvrgb_pkg::*;

	pix_item_t  in_item;
	hue_item_t  hue_item;
	rgb_item_t  rgb_item;
	rgb_item_t  res_item;
	logic       hue_valid, hue_ready;
	logic       rgb_valid, rgb_ready;

	// Gather the input fields into one item.
	always_comb begin
		in_item.opcode      = pixel_item.opcode;
		in_item.pixel_index = pixel_item.pixel_index;
		in_item.red         = pixel_item.red_in;
		in_item.green       = pixel_item.green_in;
		in_item.blue        = pixel_item.blue_in;
		in_item.hue         = pixel_item.hue;
		in_item.saturation  = pixel_item.saturation;
		in_item.value_level = pixel_item.value_level;
	end

	hsvrgb_hue_reduce u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_item.valid),
		.in_ready  (pixel_item.ready),
		.in_item   (in_item),
		.out_valid (hue_valid),
		.out_ready (hue_ready),
		.out_item  (hue_item)
	);

	hsvrgb_convert u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.in_ready  (hue_ready),
		.in_item   (hue_item),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.out_item  (rgb_item)
	);

	hsvrgb_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain_we    (gain_we),
		.gain_wdata (gain_wdata),
		.in_valid   (rgb_valid),
		.in_ready   (rgb_ready),
		.in_item    (rgb_item),
		.out_valid  (color_item.valid),
		.out_ready  (color_item.ready),
		.out_item   (res_item)
	);

	// Spread the result item onto the output fields.
	assign color_item.pixel_addr = res_item.pixel_index;
	assign color_item.red_out    = res_item.red;
	assign color_item.green_out  = res_item.green;
	assign color_item.blue_out   = res_item.blue;

endmodule

>>> dv/tb_hsv_to_rgb_brightness.sv
// Self-checking testbench for the HSV to RGB brightness pipeline, predicting every colour.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_brightness;
	import hsvrgb_pkg::*;

	// Tracks the gain in force and the colours still owed by the block, oldest first.
	class pixel_scoreboard;
		rgb_item_t         owed_colors[$];
		logic [GAIN_W-1:0] gain;
		int unsigned       failures;

		function new();
			gain     = GAIN_FULL;
			failures = 0;
		endfunction

		// Works out the scaled colour of one pixel write under the current gain.
		function rgb_item_t convert_pixel(pix_item_t p);
			int unsigned h, s, v, hi, lo, sector, adj, r, g, b, gn;
			rgb_item_t   c;
			r  = p.red;
			g  = p.green;
			b  = p.blue;
			if (p.opcode == OP_HSV) begin
				h      = p.hue % HUE_CIRCLE;
				s      = (p.saturation > PCT_FULL) ? PCT_FULL : p.saturation;
				v      = (p.value_level > PCT_FULL) ? PCT_FULL : p.value_level;
				hi     = v * LEVEL_FULL / PCT_FULL;
				lo     = hi * (PCT_FULL - s) / PCT_FULL;
				sector = h / SECTOR_DEG;
				adj    = (hi - lo) * (h % SECTOR_DEG) / SECTOR_DEG;
				case (sector[2:0])
					SEC_RED_YEL: begin r = hi;       g = lo + adj; b = lo;       end
					SEC_YEL_GRN: begin r = hi - adj; g = hi;       b = lo;       end
					SEC_GRN_CYN: begin r = lo;       g = hi;       b = lo + adj; end
					SEC_CYN_BLU: begin r = lo;       g = hi - adj; b = hi;       end
					SEC_BLU_MAG: begin r = lo + adj; g = lo;       b = hi;       end
					default:     begin r = hi;       g = lo;       b = hi - adj; end
				endcase
			end
			// Gains above full scale act as full scale.
			gn = (gain > GAIN_FULL) ? GAIN_FULL : gain;
			c.pixel_index = p.pixel_index;
			c.red         = CH_W'((r * gn) / GAIN_FULL);
			c.green       = CH_W'((g * gn) / GAIN_FULL);
			c.blue        = CH_W'((b * gn) / GAIN_FULL);
			return c;
		endfunction

		function void note_pixel(pix_item_t p);
			owed_colors.push_back(convert_pixel(p));
		endfunction

		function void report_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
					act_v);
				failures++;
			end
		endfunction

		function void check_color(rgb_item_t act);
			rgb_item_t exp_c;
			if (owed_colors.size() == 0) begin
				$display("%0t: unexpected colour, expected none, actual %0d %0d %0d %0d",
					$time, act.pixel_index, act.red, act.green, act.blue);
				failures++;
				return;
			end
			exp_c = owed_colors.pop_front();
			if ($isunknown(act)) begin
				$display("%0t: unknown bits in colour, expected %h, actual %h", $time, exp_c,
					act);
				failures++;
				return;
			end
			report_field("pixel_addr", exp_c.pixel_index, act.pixel_index);
			report_field("red_out", exp_c.red, act.red);
			report_field("green_out", exp_c.green, act.green);
			report_field("blue_out", exp_c.blue, act.blue);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              gain_we;
	logic [GAIN_W-1:0] gain_wdata;

	hsvrgb_in_if  pix_if();
	hsvrgb_out_if col_if();

	pixel_scoreboard sb;

	// Sender burst state and receiver stall pattern.
	int unsigned burst_left;
	int unsigned idle_left;
	bit          sender_steady;
	logic [15:0] stall_pattern;
	int unsigned pattern_age;

	hsv_to_rgb_brightness u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain_we    (gain_we),
		.gain_wdata (gain_wdata),
		.pixel_item (pix_if),
		.color_item (col_if)
	);

	always #10 clk = ~clk;

	// Known values on every input from time zero.
	initial begin
		sb                 = new();
		clk                = 1'b0;
		arst_n             = 1'b0;
		gain_we            = 1'b0;
		gain_wdata         = '0;
		pix_if.valid       = 1'b0;
		pix_if.opcode      = OP_RGB;
		pix_if.pixel_index = '0;
		pix_if.red_in      = '0;
		pix_if.green_in    = '0;
		pix_if.blue_in     = '0;
		pix_if.hue         = '0;
		pix_if.saturation  = '0;
		pix_if.value_level = '0;
		col_if.ready       = 1'b0;
		burst_left         = 1;
		idle_left          = 0;
		sender_steady      = 1'b0;
		stall_pattern      = 16'hffff;
		pattern_age        = 0;
	end

	// Accepted items on both channels, seen at the rising edge.
	always @(posedge clk) begin
		pix_item_t p;
		rgb_item_t c;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			p.opcode      = pix_if.opcode;
			p.pixel_index = pix_if.pixel_index;
			p.red         = pix_if.red_in;
			p.green       = pix_if.green_in;
			p.blue        = pix_if.blue_in;
			p.hue         = pix_if.hue;
			p.saturation  = pix_if.saturation;
			p.value_level = pix_if.value_level;
			sb.note_pixel(p);
		end
		if (arst_n && col_if.valid && col_if.ready) begin
			c.pixel_index = col_if.pixel_addr;
			c.red         = col_if.red_out;
			c.green       = col_if.green_out;
			c.blue        = col_if.blue_out;
			sb.check_color(c);
		end
	end

	// Receiver: rotates a stall pattern that is replaced every so often.
	always @(negedge clk) begin
		if (pattern_age == 0) begin
			pattern_age = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0:       stall_pattern = 16'hffff;
				1:       stall_pattern = 16'($urandom) | 16'h0001;
				2:       stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
				default: stall_pattern = 16'($urandom) | 16'($urandom);
			endcase
		end
		pattern_age--;
		col_if.ready  = stall_pattern[0];
		stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
	end

	// Offers one pixel write, idling first when a burst has run out.
	task automatic send_pixel(input pix_item_t p);
		@(negedge clk);
		while (idle_left > 0) begin
			pix_if.valid = 1'b0;
			idle_left--;
			@(negedge clk);
		end
		pix_if.valid       = 1'b1;
		pix_if.opcode      = p.opcode;
		pix_if.pixel_index = p.pixel_index;
		pix_if.red_in      = p.red;
		pix_if.green_in    = p.green;
		pix_if.blue_in     = p.blue;
		pix_if.hue         = p.hue;
		pix_if.saturation  = p.saturation;
		pix_if.value_level = p.value_level;
		do @(posedge clk); while (!pix_if.ready);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle_left  = sender_steady ? 0 : $urandom_range(1, 6);
		end
	endtask

	// Drops valid and waits until every owed colour has come out.
	task automatic drain_pipeline();
		@(negedge clk);
		pix_if.valid = 1'b0;
		while (sb.owed_colors.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		@(negedge clk);
		gain_we    = 1'b1;
		gain_wdata = g;
		@(posedge clk);
		sb.gain = g;
		@(negedge clk);
		gain_we = 1'b0;
	endtask

	function automatic pix_item_t make_pixel(logic op, int unsigned idx, int unsigned r,
		int unsigned g, int unsigned b, int unsigned h, int unsigned s, int unsigned v);
		pix_item_t p;
		p.opcode      = op;
		p.pixel_index = IDX_W'(idx);
		p.red         = CH_W'(r);
		p.green       = CH_W'(g);
		p.blue        = CH_W'(b);
		p.hue         = HUE_W'(h);
		p.saturation  = PCT_W'(s);
		p.value_level = PCT_W'(v);
		return p;
	endfunction

	// Percent mostly in range, sometimes past full scale.
	function automatic int unsigned random_percent();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
	endfunction

	function automatic pix_item_t random_pixel();
		int unsigned h;
		case ($urandom_range(0, 3))
			0:       h = $urandom_range(0, 65535);
			1:       h = $urandom_range(0, 359);
			2:       h = 60 * $urandom_range(0, 5) + 59 * $urandom_range(0, 1)
				+ 360 * $urandom_range(0, 180);
			default: h = 65535 - $urandom_range(0, 400);
		endcase
		return make_pixel(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
			h, random_percent(), random_percent());
	endfunction

	// Main sequence: reset, directed writes, then random phases over several gains.
	initial begin
		logic [GAIN_W-1:0] gains[8];
		int unsigned       leftover;
		gains = '{9'd0, 9'd511, 9'd257, 9'd1, 9'd255, 9'd128, 9'd0, 9'd256};
		gains[6] = GAIN_W'($urandom);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed writes at the reset gain: channel extremes, the sector edges at 0, 60 and
		// 300 degrees, hue wrap, percent clamping and ignored fields.
		send_pixel(make_pixel(OP_RGB, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(OP_RGB, 1023, 255, 255, 255, 65535, 127, 127));
		send_pixel(make_pixel(OP_RGB, 512, 255, 0, 128, 123, 50, 50));
		send_pixel(make_pixel(OP_HSV, 1, 255, 255, 255, 0, 100, 100));
		send_pixel(make_pixel(OP_HSV, 2, 0, 0, 0, 59, 100, 100));
		send_pixel(make_pixel(OP_HSV, 3, 0, 0, 0, 60, 100, 100));
		send_pixel(make_pixel(OP_HSV, 4, 0, 0, 0, 150, 70, 90));
		send_pixel(make_pixel(OP_HSV, 5, 0, 0, 0, 200, 40, 100));
		send_pixel(make_pixel(OP_HSV, 6, 0, 0, 0, 270, 100, 60));
		send_pixel(make_pixel(OP_HSV, 7, 0, 0, 0, 330, 80, 80));
		send_pixel(make_pixel(OP_HSV, 8, 0, 0, 0, 359, 100, 100));
		send_pixel(make_pixel(OP_HSV, 9, 0, 0, 0, 360, 100, 100));
		send_pixel(make_pixel(OP_HSV, 10, 0, 0, 0, 65535, 100, 100));
		send_pixel(make_pixel(OP_HSV, 11, 0, 0, 0, 100, 0, 100));
		send_pixel(make_pixel(OP_HSV, 12, 0, 0, 0, 45, 101, 127));
		send_pixel(make_pixel(OP_HSV, 13, 0, 0, 0, 300, 127, 101));
		send_pixel(make_pixel(OP_HSV, 14, 0, 0, 0, 20, 50, 0));
		send_pixel(make_pixel(OP_HSV, 1023, 0, 0, 0, 239, 100, 1));
		drain_pipeline();

		// Random phases, one gain each; one phase keeps the sender busy every cycle.
		foreach (gains[i]) begin
			write_gain(gains[i]);
			sender_steady = (i == 2);
			repeat (62) send_pixel(random_pixel());
			drain_pipeline();
		end

		repeat (20) @(posedge clk);
		leftover = sb.owed_colors.size();
		if (leftover != 0) begin
			$display("%0t: colours missing, expected 0 outstanding, actual %0d", $time,
				leftover);
			sb.failures += leftover;
		end
		if (sb.failures == 0)
			$display("hsv_to_rgb_brightness test passed");
		else
			$display("hsv_to_rgb_brightness test failed");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("hsv_to_rgb_brightness test failed");
		$finish;
	end

endmodule
